// ===== sv/rvq_pkg.sv =====
// Shared types, codes and defaults for the variable record ring queue.
`timescale 1ns / 1ps

package rvq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF    = 16;
	localparam int unsigned MAX_RECORD_LEN_DEF = 32;

	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_POP   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [2:0] KIND_PUSHED   = 3'd0;
	localparam logic [2:0] KIND_FULL     = 3'd1;
	localparam logic [2:0] KIND_TOO_LONG = 3'd2;
	localparam logic [2:0] KIND_POPPED   = 3'd3;
	localparam logic [2:0] KIND_EMPTY    = 3'd4;
	localparam logic [2:0] KIND_CLEARED  = 3'd5;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] element_value;
		logic               element_last;
	} req_item_t;

	typedef struct packed {
		logic [2:0]         result_kind;
		logic signed [31:0] out_value;
		logic               out_last;
		logic [4:0]         record_count;
	} rsp_item_t;

	typedef struct packed {
		logic push;
		logic clear;
		logic empty;
		logic pop_start;
		logic elem_rd;
		logic elem_emit;
	} rvq_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic rd_done;
		logic emit_last;
		logic out_free;
	} rvq_sts_t;

endpackage

// ===== sv/rvq_ctrl.sv =====
// Controller state machine that sequences pushes, pops and clears of the record queue.
`timescale 1ns / 1ps

module rvq_ctrl
	import rvq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  logic [1:0] action,
	input  rvq_sts_t  sts,
	output rvq_cmd_t  cmd
);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_STREAM = 1'b1;

	logic state_q, state_d;
	logic rdv_q, rdv_d;
	logic accept;

	assign req_ready = (state_q == ST_IDLE) && sts.out_free;
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		rdv_d   = rdv_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (action)
						ACT_PUSH: begin
							cmd.push = 1'b1;
						end
						ACT_POP: begin
							if (sts.count_zero) begin
								cmd.empty = 1'b1;
							end else begin
								cmd.pop_start = 1'b1;
								state_d       = ST_STREAM;
							end
						end
						ACT_CLEAR: begin
							cmd.clear = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_STREAM: begin
				cmd.elem_emit = rdv_q && sts.out_free;
				cmd.elem_rd   = !sts.rd_done && (!rdv_q || cmd.elem_emit);
				if (cmd.elem_rd) begin
					rdv_d = 1'b1;
				end else if (cmd.elem_emit) begin
					rdv_d = 1'b0;
				end
				if (cmd.elem_emit && sts.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rdv_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			rdv_q   <= rdv_d;
		end
	end

endmodule

// ===== sv/rvq_dp.sv =====
// Datapath of the record queue: pointers, slot and length memories, and the result register.
`timescale 1ns / 1ps

module rvq_dp
	import rvq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
	parameter int unsigned MAX_RECORD_LEN = MAX_RECORD_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_item_t req,
	input  rvq_cmd_t  cmd,
	output rvq_sts_t  sts,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	localparam int unsigned HW  = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned SW  = CW + 1;
	localparam int unsigned PW  = $clog2(MAX_RECORD_LEN + 1);
	localparam int unsigned SAW = $clog2(QUEUE_DEPTH * MAX_RECORD_LEN);
	localparam int unsigned SLOTS = QUEUE_DEPTH * MAX_RECORD_LEN;

	logic signed [31:0] slot_mem [SLOTS];
	logic [PW-1:0]      len_mem  [QUEUE_DEPTH];

	logic [HW-1:0] head_q;
	logic [CW-1:0] count_q, count_d;
	logic [PW-1:0] wpos_q;
	logic          ovf_q;
	logic [HW-1:0] pop_h_q;
	logic [PW-1:0] rd_idx_q, emit_idx_q;
	logic [PW-1:0] len_rd_q;
	logic signed [31:0] slot_rd_q;
	logic          out_valid_q;

	logic [SW-1:0] tsum, tail_w;
	logic [HW-1:0] tail;
	logic          full, room, ovf_eff;
	logic [PW-1:0] len_eff;
	logic [2:0]    push_kind;
	logic [SAW-1:0] wr_addr, rd_addr;
	logic          load_single;
	logic [2:0]    single_kind;

	assign tsum   = SW'(head_q) + SW'(count_q);
	assign tail_w = (tsum >= SW'(QUEUE_DEPTH)) ? tsum - SW'(QUEUE_DEPTH) : tsum;
	assign tail   = tail_w[HW-1:0];
	assign full   = (count_q == CW'(QUEUE_DEPTH));
	assign room   = (wpos_q < PW'(MAX_RECORD_LEN));
	assign ovf_eff = ovf_q || !room;

	assign wr_addr = SAW'(tail) * SAW'(MAX_RECORD_LEN) + SAW'(wpos_q);
	assign rd_addr = SAW'(pop_h_q) * SAW'(MAX_RECORD_LEN) + SAW'(rd_idx_q);

	always_comb begin
		if (len_rd_q == '0) begin
			len_eff = PW'(1);
		end else if (len_rd_q > PW'(MAX_RECORD_LEN)) begin
			len_eff = PW'(MAX_RECORD_LEN);
		end else begin
			len_eff = len_rd_q;
		end
	end

	always_comb begin
		if (full) begin
			push_kind = KIND_FULL;
		end else if (ovf_eff) begin
			push_kind = KIND_TOO_LONG;
		end else begin
			push_kind = KIND_PUSHED;
		end
	end

	assign sts.count_zero = (count_q == '0);
	assign sts.rd_done    = (rd_idx_q == len_eff);
	assign sts.emit_last  = (emit_idx_q == len_eff - PW'(1));
	assign sts.out_free   = !out_valid_q || rsp_ready;

	always_comb begin
		count_d = count_q;
		if (cmd.clear) begin
			count_d = '0;
		end else if (cmd.push && req.element_last && push_kind == KIND_PUSHED) begin
			count_d = count_q + CW'(1);
		end else if (cmd.pop_start) begin
			count_d = count_q - CW'(1);
		end
	end

	assign load_single = (cmd.push && req.element_last) || cmd.clear || cmd.empty;

	always_comb begin
		if (cmd.clear) begin
			single_kind = KIND_CLEARED;
		end else if (cmd.empty) begin
			single_kind = KIND_EMPTY;
		end else begin
			single_kind = push_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			wpos_q      <= '0;
			ovf_q       <= 1'b0;
			rd_idx_q    <= '0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cmd.clear) begin
				head_q <= '0;
				wpos_q <= '0;
				ovf_q  <= 1'b0;
			end else if (cmd.push) begin
				if (req.element_last) begin
					wpos_q <= '0;
					ovf_q  <= 1'b0;
				end else if (room) begin
					wpos_q <= wpos_q + PW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end else if (cmd.pop_start) begin
				head_q <= (head_q == HW'(QUEUE_DEPTH - 1)) ? '0 : head_q + HW'(1);
			end
			if (cmd.pop_start) begin
				rd_idx_q   <= '0;
				emit_idx_q <= '0;
			end else begin
				if (cmd.elem_rd) begin
					rd_idx_q <= rd_idx_q + PW'(1);
				end
				if (cmd.elem_emit) begin
					emit_idx_q <= emit_idx_q + PW'(1);
				end
			end
			if (load_single || cmd.elem_emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && room && !full) begin
			slot_mem[wr_addr] <= req.element_value;
		end
		if (cmd.push && req.element_last && push_kind == KIND_PUSHED) begin
			len_mem[tail] <= wpos_q + PW'(1);
		end
		if (cmd.pop_start) begin
			pop_h_q  <= head_q;
			len_rd_q <= len_mem[head_q];
		end
		if (cmd.elem_rd) begin
			slot_rd_q <= slot_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load_single) begin
			rsp.result_kind  <= single_kind;
			rsp.out_value    <= '0;
			rsp.out_last     <= 1'b1;
			rsp.record_count <= 5'(count_d);
		end else if (cmd.elem_emit) begin
			rsp.result_kind  <= KIND_POPPED;
			rsp.out_value    <= slot_rd_q;
			rsp.out_last     <= sts.emit_last;
			rsp.record_count <= 5'(count_q);
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

// ===== sv/variable_record_ring_queue.sv =====
// Top level of the variable record ring queue: controller plus datapath.
`timescale 1ns / 1ps

// A ring of QUEUE_DEPTH slots, each holding one record of 1 to MAX_RECORD_LEN signed words.
// Each push beat carries one element; the beat with element_last set closes the record
// and commits it if it fits, giving one result beat, as do a clear and a pop on an empty queue.
// A pop of a record of length L streams L result beats at one per cycle while the result
// register can be refilled, after a start of a length memory read, then the first slot memory
// read, since the slot memory has one registered read port. The next request beat is taken
// once the last beat of the previous item is in the result register and that register can
// be refilled. Results report the record count after the item, truncated to five bits.
module variable_record_ring_queue
	import rvq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
	parameter int unsigned MAX_RECORD_LEN = MAX_RECORD_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	rvq_cmd_t cmd;
	rvq_sts_t sts;

	rvq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.action    (req.action),
		.sts       (sts),
		.cmd       (cmd)
	);

	rvq_dp #(
		.QUEUE_DEPTH    (QUEUE_DEPTH),
		.MAX_RECORD_LEN (MAX_RECORD_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
